// File: hw/rtl/bphi_pkg.sv
// shared types, constants and helpers for the bucket probe hash insert unit
// no dependencies; imported by the controller, datapath and top level
package bphi_pkg;

  localparam int START_SLOTS  = 16;
  localparam int SIZE_LEVELS  = 7;
  localparam int BUCKET_SLOTS = 4;
  localparam int BANK_DEPTH   = START_SLOTS << (SIZE_LEVELS - 1);
  localparam int ADDR_W       = $clog2(BANK_DEPTH);
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS);
  localparam int LEVEL_W      = 3;
  localparam int CNT_W        = 11;
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 64;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOCKED = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] table_size;
    logic [CNT_W-1:0] key_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       clr_all;
    logic       clr_a;
    logic       clr_new;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       i_clr;
    logic       i_inc;
    logic       j_clr;
    logic       j_inc;
    logic       rd_old;
    logic       ins_wr;
    logic       live_inc;
    logic       rh_latch;
    logic       rh_wr;
    logic       cnt_inc;
    logic       grow_commit;
    logic       clear_commit;
    logic       load_out;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic lock;
    logic sweep_last;
    logic i_last;
    logic j_last;
    logic level_max;
    logic ins_hit;
    logic ins_empty;
    logic old_zero;
    logic rh_hit;
    logic rh_empty;
  } stat_t;

  // slot index mask for a table of START_SLOTS << level slots
  function automatic logic [ADDR_W-1:0] level_mask(input logic [LEVEL_W-1:0] level);
    int unsigned s;
    s = (START_SLOTS << level) - 1;
    return ADDR_W'(s);
  endfunction

  // first slot of the bucket a key maps to
  function automatic logic [ADDR_W-1:0] bucket_base(input logic [KEY_W-1:0] key,
                                                    input logic [LEVEL_W-1:0] level);
    return key[ADDR_W-1:0] & level_mask(level) & ~ADDR_W'(BUCKET_SLOTS - 1);
  endfunction

  function automatic logic [CNT_W-1:0] slots_at(input logic [LEVEL_W-1:0] level);
    return CNT_W'(START_SLOTS << level);
  endfunction

endpackage

// File: hw/rtl/bphi_datapath.sv
// datapath: key/value banks, item and rehash registers, counters, result register
// depends on bphi_pkg; driven by bphi_controller through cmd_t
module bphi_datapath
  import bphi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t out_data
);

  logic [KEY_W-1:0] keys_mem [2][BANK_DEPTH];
  logic [VAL_W-1:0] vals_mem [2][BANK_DEPTH];
  logic [KEY_W-1:0] rd_key [2];
  logic [VAL_W-1:0] rd_val [2];

  logic               item_op;
  logic [KEY_W-1:0]   item_key;
  logic [VAL_W-1:0]   item_val;
  logic [KEY_W-1:0]   rh_key;
  logic [VAL_W-1:0]   rh_val;
  logic               lock;
  logic               active;
  logic [LEVEL_W-1:0] level;
  logic [CNT_W-1:0]   live;
  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  sweep;
  logic [ADDR_W-1:0]  idx;
  logic [SLOT_W-1:0]  slot;

  logic [ADDR_W-1:0]  pa_ins;
  logic [ADDR_W-1:0]  pa_rh;
  logic               we [2];
  logic [ADDR_W-1:0]  wa [2];
  logic [KEY_W-1:0]   wk [2];
  logic [VAL_W-1:0]   wv [2];
  logic [ADDR_W-1:0]  ra [2];

  // probe addresses: active table for inserts, doubled table for rehash
  assign pa_ins = bucket_base(item_key, level) | ADDR_W'(slot);
  assign pa_rh  = bucket_base(rh_key, level + LEVEL_W'(1)) | ADDR_W'(slot);

  // per-bank write and read port selection
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      we[k] = 1'b0;
      wa[k] = sweep;
      wk[k] = '0;
      wv[k] = '0;
      if (cmd.clr_all || (cmd.clr_a && k == 0) || (cmd.clr_new && (k != 32'(active)))) begin
        we[k] = 1'b1;
      end else if (cmd.ins_wr && (k == 32'(active))) begin
        we[k] = 1'b1;
        wa[k] = pa_ins;
        wk[k] = item_key;
        wv[k] = item_val;
      end else if (cmd.rh_wr && (k != 32'(active))) begin
        we[k] = 1'b1;
        wa[k] = pa_rh;
        wk[k] = rh_key;
        wv[k] = rh_val;
      end
      if (k == 32'(active)) begin
        ra[k] = cmd.rd_old ? idx : pa_ins;
      end else begin
        ra[k] = pa_rh;
      end
    end
  end

  // bank memories with registered reads
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (we[k]) begin
        keys_mem[k][wa[k]] <= wk[k];
        vals_mem[k][wa[k]] <= wv[k];
      end
      rd_key[k] <= keys_mem[k][ra[k]];
      rd_val[k] <= vals_mem[k][ra[k]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op  <= in_data.operation;
      item_key <= in_data.key;
      item_val <= in_data.value;
    end
    if (cmd.rh_latch) begin
      rh_key <= rd_key[active];
      rh_val <= rd_val[active];
    end
    if (cmd.load_out) begin
      out_data.status     <= cmd.status;
      out_data.table_size <= slots_at(level);
      out_data.key_count  <= live;
    end
  end

  // table state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lock   <= 1'b0;
      active <= 1'b0;
      level  <= '0;
      live   <= '0;
      count  <= '0;
      sweep  <= '0;
      idx    <= '0;
      slot   <= '0;
    end else begin
      if (cfg_we) lock <= cfg_wdata;
      if (cmd.sweep_clr) sweep <= '0;
      else if (cmd.sweep_inc) sweep <= sweep + ADDR_W'(1);
      if (cmd.i_clr) begin
        idx   <= '0;
        count <= '0;
      end else begin
        if (cmd.i_inc) idx <= idx + ADDR_W'(1);
        if (cmd.cnt_inc) count <= count + CNT_W'(1);
      end
      if (cmd.j_clr) slot <= '0;
      else if (cmd.j_inc) slot <= slot + SLOT_W'(1);
      if (cmd.clear_commit) begin
        active <= 1'b0;
        level  <= '0;
        live   <= '0;
      end else if (cmd.grow_commit) begin
        // the last old entry may be stored in the same cycle
        active <= ~active;
        level  <= level + LEVEL_W'(1);
        live   <= count + CNT_W'(cmd.cnt_inc);
      end else if (cmd.live_inc) begin
        live <= live + CNT_W'(1);
      end
    end
  end

  // status flags
  always_comb begin
    stat.op         = item_op;
    stat.lock       = lock;
    stat.sweep_last = (sweep == ADDR_W'(BANK_DEPTH - 1));
    stat.i_last     = (idx == level_mask(level));
    stat.j_last     = (slot == SLOT_W'(BUCKET_SLOTS - 1));
    stat.level_max  = (32'(level) >= SIZE_LEVELS - 1);
    stat.ins_hit    = (rd_key[active] == item_key);
    stat.ins_empty  = (rd_key[active] == '0);
    stat.old_zero   = (rd_key[active] == '0);
    stat.rh_hit     = (rd_key[~active] == rh_key);
    stat.rh_empty   = (rd_key[~active] == '0);
  end

endmodule

// File: hw/rtl/bphi_controller.sv
// controller: sequences clearing, bucket probes, growth and rehash, result handoff
// depends on bphi_pkg; commands bphi_datapath through cmd_t
module bphi_controller
  import bphi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLR_ALL = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_CLR_A   = 4'd3;
  localparam logic [3:0] S_PRD     = 4'd4;
  localparam logic [3:0] S_PCHK    = 4'd5;
  localparam logic [3:0] S_GCLR    = 4'd6;
  localparam logic [3:0] S_RRD     = 4'd7;
  localparam logic [3:0] S_RCHK    = 4'd8;
  localparam logic [3:0] S_RPRD    = 4'd9;
  localparam logic [3:0] S_RPCHK   = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] res, res_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    logic adv_i;
    adv_i          = 1'b0;
    cmd            = '0;
    cmd.status     = res;
    state_next     = state;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_CLR_ALL: begin
        cmd.clr_all   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.sweep_clr = 1'b1;
        cmd.j_clr     = 1'b1;
        if (stat.op == OP_CLEAR) begin
          state_next = S_CLR_A;
        end else if (stat.lock) begin
          res_next   = ST_LOCKED;
          state_next = S_FIN;
        end else begin
          state_next = S_PRD;
        end
      end
      S_CLR_A: begin
        cmd.clr_a     = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_last) begin
          cmd.clear_commit = 1'b1;
          res_next         = ST_OK;
          state_next       = S_FIN;
        end
      end
      S_PRD: state_next = S_PCHK;
      S_PCHK: begin
        if (stat.ins_hit) begin
          res_next   = ST_OK;
          state_next = S_FIN;
        end else if (stat.ins_empty) begin
          cmd.ins_wr   = 1'b1;
          cmd.live_inc = 1'b1;
          res_next     = ST_OK;
          state_next   = S_FIN;
        end else if (!stat.j_last) begin
          cmd.j_inc  = 1'b1;
          state_next = S_PRD;
        end else if (stat.level_max) begin
          res_next   = ST_LIMIT;
          state_next = S_FIN;
        end else begin
          cmd.sweep_clr = 1'b1;
          state_next    = S_GCLR;
        end
      end
      // empty the other bank before rehashing into it
      S_GCLR: begin
        cmd.clr_new   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_last) begin
          cmd.i_clr  = 1'b1;
          state_next = S_RRD;
        end
      end
      S_RRD: begin
        cmd.rd_old = 1'b1;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (stat.old_zero) begin
          adv_i = 1'b1;
        end else begin
          cmd.rh_latch = 1'b1;
          cmd.j_clr    = 1'b1;
          state_next   = S_RPRD;
        end
      end
      S_RPRD: state_next = S_RPCHK;
      S_RPCHK: begin
        if (stat.rh_hit) begin
          adv_i = 1'b1;
        end else if (stat.rh_empty) begin
          cmd.rh_wr   = 1'b1;
          cmd.cnt_inc = 1'b1;
          adv_i       = 1'b1;
        end else if (!stat.j_last) begin
          cmd.j_inc  = 1'b1;
          state_next = S_RPRD;
        end else begin
          adv_i = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // next old entry, or switch banks and retry the insert
    if (adv_i) begin
      if (stat.i_last) begin
        cmd.grow_commit = 1'b1;
        cmd.j_clr       = 1'b1;
        state_next      = S_PRD;
      end else begin
        cmd.i_inc  = 1'b1;
        state_next = S_RRD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_ALL;
      res       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res       <= res_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hw/rtl/bucket_probe_hash_insert_unit.sv
// Bucket probe hash insert unit: a key/value insert engine over a doubling hash table.
// Input items (operation, key, value) arrive on in_valid/in_ready; one result
// (status, table_size, key_count) per item leaves on out_valid/out_ready.
// cfg_we/cfg_wdata write the insert lock; write it only while the unit is idle.
// After reset a clearing pass runs over both banks with in_ready low.
// An item is taken only when in_ready is high; one item is worked at a time.
// An insert that finds its key or an empty slot probes its bucket slot by slot,
// each probe a read state and a check state around the registered bank read.
// in_ready returns in the cycle after the result is loaded; a locked insert
// goes from dispatch straight to its result. A clear sweeps bank a.
// A full bucket grows the table: a sweep that empties the other bank, then a read
// and check of each old slot and a probe of its new bucket for each nonzero key,
// and the insert is retried, possibly growing again.
// The result sits in an output register, so the next item can be accepted while
// a result waits; a stalled receiver holds the unit only when a second result is
// finished before the first is taken. Depends on bphi_pkg, bphi_controller, bphi_datapath.
module bucket_probe_hash_insert_unit
  import bphi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  bphi_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bphi_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // status never carries the unused code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status != 2'd3))
    else $error("bad result status");

  // live keys never exceed the slot count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.key_count <= out_data.table_size))
    else $error("key count above table size");
`endif

endmodule

// File: tb/tb.sv
// testbench for the bucket probe hash insert unit: random and directed inserts and clears
// checked against a behavioral table model; depends on bphi_pkg and the unit's rtl
`timescale 1ns / 100ps

module tb;
  import bphi_pkg::*;

  // predicted table contents and expected result queue
  class hash_table_scoreboard;
    logic [KEY_W-1:0] keys [2][BANK_DEPTH];
    logic [VAL_W-1:0] vals [2][BANK_DEPTH];
    int unsigned      bank;
    int unsigned      level;
    int unsigned      live;
    bit               lock;
    out_item_t        pending [$];
    int unsigned      errors;

    function void reset_state();
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < BANK_DEPTH; i++) begin
          keys[b][i] = '0;
          vals[b][i] = '0;
        end
      bank = 0;
      level = 0;
      live = 0;
      lock = 0;
      errors = 0;
    endfunction

    // 0 present, 1 stored, 2 bucket full
    function int put_bucket(int b, int unsigned slots, logic [KEY_W-1:0] k,
                            logic [VAL_W-1:0] v);
      int unsigned base;
      base = int'(k[ADDR_W-1:0]) & (slots - 1) & ~(BUCKET_SLOTS - 1);
      for (int j = 0; j < BUCKET_SLOTS; j++) begin
        if (keys[b][base+j] == k) return 0;
        if (keys[b][base+j] == '0) begin
          keys[b][base+j] = k;
          vals[b][base+j] = v;
          return 1;
        end
      end
      return 2;
    endfunction

    function logic [1:0] insert_key(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int r;
      int unsigned slots, cnt, nb;
      forever begin
        slots = START_SLOTS << level;
        r = put_bucket(bank, slots, k, v);
        if (r == 1) live = (live + 1) & 11'h7ff;
        if (r != 2) return ST_OK;
        if (level >= SIZE_LEVELS - 1) return ST_LIMIT;
        // rehash into the other bank in index order
        nb = 1 - bank;
        for (int i = 0; i < BANK_DEPTH; i++) keys[nb][i] = '0;
        cnt = 0;
        for (int i = 0; i < slots; i++)
          if (keys[bank][i] != '0 &&
              put_bucket(nb, slots << 1, keys[bank][i], vals[bank][i]) == 1)
            cnt++;
        bank = nb;
        level++;
        live = cnt & 11'h7ff;
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      e.status = ST_OK;
      if (it.operation == OP_CLEAR) begin
        for (int i = 0; i < BANK_DEPTH; i++) keys[0][i] = '0;
        bank = 0;
        level = 0;
        live = 0;
      end else if (lock) begin
        e.status = ST_LOCKED;
      end else begin
        e.status = insert_key(it.key, it.value);
      end
      e.table_size = CNT_W'(START_SLOTS << level);
      e.key_count = CNT_W'(live);
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.table_size !== e.table_size) begin
        $display("%0t: table_size expected %0d actual %0d", $time, e.table_size,
                 got.table_size);
        errors++;
      end
      if (got.key_count !== e.key_count) begin
        $display("%0t: key_count expected %0d actual %0d", $time, e.key_count,
                 got.key_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;
  bit        calm;

  hash_table_scoreboard sb;

  bucket_probe_hash_insert_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver side: random stall, check on each transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // valid drops only in idle cycles, so back-to-back items keep it high
  task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{operation: op, key: k, value: v};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_lock(bit l);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= l;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.lock = l;
  endtask

  // keys clustered in a small low-bit range so buckets fill and the table grows
  function automatic logic [KEY_W-1:0] rand_key(int span);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    k[ADDR_W-1:0] = ADDR_W'($urandom_range(span - 1));
    if ($urandom_range(9) == 0) k = {$urandom, $urandom};
    return k;
  endfunction

  initial begin
    logic [KEY_W-1:0] k;
    sb = new();
    sb.reset_state();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    calm = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed: extremes, zero key, duplicate, bucket overflow, lock, clear
    send_item(OP_INSERT, '0, '1);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, '1, '0);
    send_item(OP_INSERT, 64'h1, 64'h0);
    for (int i = 0; i < 5; i++)
      send_item(OP_INSERT, 64'h100 * VAL_W'(i + 1) + 64'h4, VAL_W'(i));
    for (int i = 0; i < 6; i++)
      send_item(OP_INSERT, (64'h1 << (40 + i)) | 64'h8, VAL_W'(i));
    set_lock(1);
    send_item(OP_INSERT, 64'h55, 64'h1);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_INSERT, 64'h77, 64'h2);
    set_lock(0);
    send_item(OP_INSERT, 64'h8000_0000_0000_0003, 64'h3);
    // keys with equal low bits force growth until the size limit
    for (int i = 0; i < 6; i++)
      send_item(OP_INSERT, (64'h1 << (20 + i)) | 64'hc, VAL_W'(i));

    // random phases with several lock settings
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      if (ph == 2) set_lock(1);
      if (ph == 3) set_lock(0);
      for (int n = 0; n < 210; n++) begin
        k = rand_key(ph == 5 ? 1024 : (ph % 2 ? 64 : 256));
        if ($urandom_range(99) < 2) send_item(OP_CLEAR, {$urandom, $urandom}, '1);
        else if ($urandom_range(99) < 3) send_item(OP_INSERT, '0, {$urandom, $urandom});
        else send_item(OP_INSERT, k, {$urandom, $urandom});
      end
    end
    calm = 0;

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bucket_probe_hash_insert_unit test passed");
    end else begin
      $display("bucket_probe_hash_insert_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("bucket_probe_hash_insert_unit test failed");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/bphi_pkg.sv
hw/rtl/bphi_datapath.sv
hw/rtl/bphi_controller.sv
hw/rtl/bucket_probe_hash_insert_unit.sv
tb/tb.sv
